### sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/tst_pkg.sv
`timescale 1ns / 1ps

package tst_pkg;

	// Operation codes.
	localparam logic [1:0] FUNC_APPEND    = 2'd0;
	localparam logic [1:0] FUNC_REUSE     = 2'd1;
	localparam logic [1:0] FUNC_SET_STATE = 2'd2;
	localparam logic [1:0] FUNC_SET_SP    = 2'd3;

	// Task states.
	localparam logic [1:0] TASK_READY   = 2'd1;
	localparam logic [1:0] TASK_DORMANT = 2'd2;
	localparam logic [1:0] TASK_INVALID = 2'd3;

	// Status codes.
	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_FULL      = 3'd1;
	localparam logic [2:0] STATUS_LIMIT     = 3'd2;
	localparam logic [2:0] STATUS_NO_FIT    = 3'd3;
	localparam logic [2:0] STATUS_BAD_STATE = 3'd4;
	localparam logic [2:0] STATUS_BAD_TID   = 3'd5;
	localparam logic [2:0] STATUS_NOT_FOUND = 3'd6;

	localparam logic [31:0] FRAME_BYTES      = 32'd64;
	localparam logic [5:0]  MAX_ACTIVE_RESET = 6'd16;
	localparam int          QUEUE_DEPTH      = 2;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  tid;
		logic [1:0]  new_state;
		logic [15:0] stack_bytes;
		logic [31:0] stack_top;
		logic [31:0] entry_address;
		logic [31:0] deadline;
		logic [31:0] run_left;
		logic [31:0] alloc_addr;
		logic [31:0] stack_pointer;
		logic [2:0]  pre_status;
	} item_t;

	typedef struct packed {
		logic [7:0]  tid;
		logic [1:0]  task_state;
		logic [15:0] stack_bytes;
	} meta_t;

	typedef struct packed {
		logic [31:0] stack_top;
		logic [31:0] entry_address;
		logic [31:0] deadline;
		logic [31:0] run_left;
		logic [31:0] alloc_addr;
	} ctx_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  slot;
		logic [31:0] initial_stack_pointer;
		logic [5:0]  active_count;
	} result_t;

endpackage

### sv/tst_front.sv
`timescale 1ns / 1ps

module tst_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  tst_pkg::item_t  in_item,
	input  logic [5:0]      max_active,
	input  logic            q_full,
	output logic            push,
	output tst_pkg::item_t  push_item,
	output logic            valid
);

	tst_pkg::item_t item_s1;
	tst_pkg::item_t cls_item;
	logic           valid_s1;
	logic [2:0]     pre_status;
	logic           is_update;

	// Errors that depend only on the item and the register are settled here.
	always_comb begin
		is_update = (in_item.func == tst_pkg::FUNC_SET_STATE) ||
			(in_item.func == tst_pkg::FUNC_SET_SP);
		if (in_item.func == tst_pkg::FUNC_SET_STATE &&
				in_item.new_state == tst_pkg::TASK_INVALID) begin
			pre_status = tst_pkg::STATUS_BAD_STATE;
		end else if (is_update && in_item.tid >= 8'(max_active)) begin
			pre_status = tst_pkg::STATUS_BAD_TID;
		end else begin
			pre_status = tst_pkg::STATUS_OK;
		end
		cls_item            = in_item;
		cls_item.pre_status = pre_status;
	end

	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;
	assign valid     = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cls_item;
		end
	end

endmodule

### sv/tst_queue.sv
`timescale 1ns / 1ps

module tst_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tst_pkg::item_t  push_item,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output tst_pkg::item_t  head
);

	localparam int PW = $clog2(tst_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(tst_pkg::QUEUE_DEPTH + 1);

	tst_pkg::item_t entries_q [tst_pkg::QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = count_q == CW'(tst_pkg::QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(tst_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(tst_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### sv/tst_back.sv
`timescale 1ns / 1ps

module tst_back #(
	parameter int TABLE_SLOTS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [5:0]        max_active,
	input  logic              q_empty,
	input  tst_pkg::item_t    q_head,
	output logic              pop,
	output logic              busy,
	output logic              done,
	output tst_pkg::result_t  result
);

	`include "assert_macros.svh"

	localparam int IW = $clog2(TABLE_SLOTS);
	localparam int FW = $clog2(TABLE_SLOTS + 1);

	localparam logic [1:0] BK_IDLE   = 2'd0;
	localparam logic [1:0] BK_CHECK  = 2'd1;
	localparam logic [1:0] BK_SEARCH = 2'd2;

	logic [1:0]        state_q, state_d;
	logic [FW-1:0]     fill_q, fill_d;
	logic [5:0]        active_q, active_d;
	logic [FW-1:0]     rd_idx_q, rd_idx_d;
	logic              pend_q, pend_d;
	logic [IW-1:0]     pend_idx_q, pend_idx_d;
	tst_pkg::item_t    work_q, work_d;

	tst_pkg::meta_t    meta_mem_q [TABLE_SLOTS];
	tst_pkg::ctx_t     ctx_mem_q [TABLE_SLOTS];
	logic [31:0]       sp_mem_q [TABLE_SLOTS];
	tst_pkg::meta_t    meta_rd_q;

	logic              meta_we;
	logic [IW-1:0]     meta_waddr;
	tst_pkg::meta_t    meta_wdata;
	logic              ctx_we;
	tst_pkg::ctx_t     ctx_wdata;
	logic              sp_we;
	logic [IW-1:0]     sp_waddr;
	logic [31:0]       sp_wdata;

	logic [31:0]       isp;
	tst_pkg::meta_t    create_meta;
	logic              hit;
	logic              fin;
	logic [2:0]        fin_status;
	logic [IW-1:0]     fin_idx;
	logic [31:0]       fin_isp;
	logic              done_q;
	tst_pkg::result_t  res_q;

	assign isp         = work_q.stack_top - tst_pkg::FRAME_BYTES;
	assign create_meta = '{tid: work_q.tid, task_state: tst_pkg::TASK_READY,
		stack_bytes: work_q.stack_bytes};
	assign ctx_wdata   = '{stack_top: work_q.stack_top, entry_address: work_q.entry_address,
		deadline: work_q.deadline, run_left: work_q.run_left,
		alloc_addr: work_q.alloc_addr};

	// A reuse looks for a dormant slot that is big enough; updates look for the tid.
	assign hit = pend_q && ((work_q.func == tst_pkg::FUNC_REUSE) ?
		(meta_rd_q.task_state == tst_pkg::TASK_DORMANT &&
			meta_rd_q.stack_bytes >= work_q.stack_bytes) :
		(meta_rd_q.tid == work_q.tid));

	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		active_d   = active_q;
		rd_idx_d   = rd_idx_q;
		pend_d     = 1'b0;
		pend_idx_d = pend_idx_q;
		work_d     = work_q;
		pop        = 1'b0;
		meta_we    = 1'b0;
		meta_waddr = '0;
		meta_wdata = create_meta;
		ctx_we     = 1'b0;
		sp_we      = 1'b0;
		sp_waddr   = '0;
		sp_wdata   = isp;
		fin        = 1'b0;
		fin_status = tst_pkg::STATUS_OK;
		fin_idx    = '0;
		fin_isp    = '0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					work_d  = q_head;
					state_d = BK_CHECK;
				end
			end
			BK_CHECK: begin
				if (work_q.pre_status != tst_pkg::STATUS_OK) begin
					fin        = 1'b1;
					fin_status = work_q.pre_status;
					state_d    = BK_IDLE;
				end else if (work_q.func == tst_pkg::FUNC_APPEND) begin
					fin     = 1'b1;
					state_d = BK_IDLE;
					if (fill_q == FW'(TABLE_SLOTS)) begin
						fin_status = tst_pkg::STATUS_FULL;
					end else if (active_q >= max_active) begin
						fin_status = tst_pkg::STATUS_LIMIT;
					end else begin
						meta_we    = 1'b1;
						meta_waddr = fill_q[IW-1:0];
						ctx_we     = 1'b1;
						sp_we      = 1'b1;
						sp_waddr   = fill_q[IW-1:0];
						fin_idx    = fill_q[IW-1:0];
						fin_isp    = isp;
						fill_d     = fill_q + 1'b1;
						active_d   = active_q + 1'b1;
					end
				end else if (work_q.func == tst_pkg::FUNC_REUSE && active_q >= max_active) begin
					fin        = 1'b1;
					fin_status = tst_pkg::STATUS_LIMIT;
					state_d    = BK_IDLE;
				end else if (fill_q == '0) begin
					fin        = 1'b1;
					fin_status = (work_q.func == tst_pkg::FUNC_REUSE) ?
						tst_pkg::STATUS_NO_FIT : tst_pkg::STATUS_NOT_FOUND;
					state_d    = BK_IDLE;
				end else begin
					rd_idx_d = '0;
					state_d  = BK_SEARCH;
				end
			end
			BK_SEARCH: begin
				// One read is issued per cycle; its data is compared the cycle after.
				if (rd_idx_q < fill_q) begin
					rd_idx_d   = rd_idx_q + 1'b1;
					pend_d     = 1'b1;
					pend_idx_d = rd_idx_q[IW-1:0];
				end
				if (hit) begin
					fin     = 1'b1;
					fin_idx = pend_idx_q;
					state_d = BK_IDLE;
					case (work_q.func)
						tst_pkg::FUNC_REUSE: begin
							meta_we    = 1'b1;
							meta_waddr = pend_idx_q;
							ctx_we     = 1'b1;
							sp_we      = 1'b1;
							sp_waddr   = pend_idx_q;
							fin_isp    = isp;
							active_d   = active_q + 1'b1;
						end
						tst_pkg::FUNC_SET_STATE: begin
							meta_we    = 1'b1;
							meta_waddr = pend_idx_q;
							meta_wdata = '{tid: meta_rd_q.tid, task_state: work_q.new_state,
								stack_bytes: meta_rd_q.stack_bytes};
							if (work_q.new_state == tst_pkg::TASK_DORMANT && active_q != '0) begin
								active_d = active_q - 1'b1;
							end
						end
						default: begin
							sp_we    = 1'b1;
							sp_waddr = pend_idx_q;
							sp_wdata = work_q.stack_pointer;
						end
					endcase
				end else if (pend_q && FW'(pend_idx_q) == fill_q - 1'b1) begin
					fin        = 1'b1;
					fin_status = (work_q.func == tst_pkg::FUNC_REUSE) ?
						tst_pkg::STATUS_NO_FIT : tst_pkg::STATUS_NOT_FOUND;
					state_d    = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem_q[meta_waddr] <= meta_wdata;
		end
		meta_rd_q <= meta_mem_q[rd_idx_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctx_we) begin
			ctx_mem_q[meta_waddr] <= ctx_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (sp_we) begin
			sp_mem_q[sp_waddr] <= sp_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			fill_q   <= '0;
			active_q <= '0;
			rd_idx_q <= '0;
			pend_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			active_q <= active_d;
			rd_idx_q <= rd_idx_d;
			pend_q   <= pend_d;
			done_q   <= fin;
		end
	end

	always_ff @(posedge clk) begin
		pend_idx_q <= pend_idx_d;
		work_q     <= work_d;
		if (fin) begin
			res_q.status                <= fin_status;
			res_q.slot                  <= 5'(fin_idx);
			res_q.initial_stack_pointer <= fin_isp;
			res_q.active_count          <= active_d;
		end
	end

	assign busy   = state_q != BK_IDLE;
	assign done   = done_q;
	assign result = res_q;

	`ASSERT_NEXT(a_done_single, clk, arst_n, done_q, !done_q, "result strobe held for two cycles")
	`ASSERT_IMPLY(a_full_status, clk, arst_n, fin && fin_status == tst_pkg::STATUS_FULL, fill_q == FW'(TABLE_SLOTS), "table full reported with free slots")
	`ASSERT_IMPLY(a_write_filled, clk, arst_n, meta_we, FW'(meta_waddr) <= fill_q, "slot written beyond the filled region")
	`ASSERT_NEXT(a_idle_count, clk, arst_n, state_q == BK_IDLE, $stable(active_q), "active count changed while idle")

endmodule

### sv/task_slot_table.sv
`timescale 1ns / 1ps
// Path: an item is registered in the front end, queued, popped by the back end and settled
// in its check state or, for reuse and updates that need it, after a serial slot search.
// Items: one at a time; a new start is taken in the cycle of the previous result,
// and the serial slot search sets the longest wait between items.
// Reset: fill index and active count clear, max_active returns to 16, slot contents
// are undefined. Results are strobed for one cycle with done; the receiver cannot stall.

module task_slot_table #(
	parameter int TABLE_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  tid,
	input  logic [1:0]  new_state,
	input  logic [15:0] stack_bytes,
	input  logic [31:0] stack_top,
	input  logic [31:0] entry_address,
	input  logic [31:0] deadline,
	input  logic [31:0] run_left,
	input  logic [31:0] alloc_addr,
	input  logic [31:0] stack_pointer,
	output logic        done,
	output logic [2:0]  status,
	output logic [4:0]  slot,
	output logic [31:0] initial_stack_pointer,
	output logic [5:0]  active_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);

	`include "assert_macros.svh"

	// The active-task limit. The user must change it only while the block is idle (the block
	// does not enforce this), so the front and back ends may read it directly without any hand-off.
	logic [5:0]       max_active_q;

	tst_pkg::item_t   in_item;
	tst_pkg::item_t   push_item;
	tst_pkg::item_t   q_head;
	tst_pkg::result_t result;
	logic             accept;
	logic             push;
	logic             front_valid;
	logic             q_full;
	logic             q_empty;
	logic             pop;
	logic             back_busy;

	// A configuration transaction is always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_active_q <= tst_pkg::MAX_ACTIVE_RESET;
		end else if (cfg_valid) begin
			max_active_q <= cfg_data;
		end
	end

	// The block works on one item at a time. It stays busy from the accepting edge
	// until the back end has produced the result, so the item may sit in the front
	// register, in the queue or in the back end.
	assign busy   = front_valid || !q_empty || back_busy;
	assign accept = start && !busy;

	assign in_item = '{func: func, tid: tid, new_state: new_state, stack_bytes: stack_bytes,
		stack_top: stack_top, entry_address: entry_address, deadline: deadline,
		run_left: run_left, alloc_addr: alloc_addr,
		stack_pointer: stack_pointer, pre_status: tst_pkg::STATUS_OK};

	// The front end registers the item and resolves the errors that need no table
	// state: an invalid target state and, for updates, a task id outside the configured range.
	tst_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_item    (in_item),
		.max_active (max_active_q),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item),
		.valid      (front_valid)
	);

	// A short queue decouples classification from execution.
	tst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	// The back end owns the slot table, the fill index and the active count. It
	// handles appends directly and walks the filled slots in order for reuse and
	// for updates, stopping at the first match.
	tst_back #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_active (max_active_q),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.pop        (pop),
		.busy       (back_busy),
		.done       (done),
		.result     (result)
	);

	assign status                = result.status;
	assign slot                  = result.slot;
	assign initial_stack_pointer = result.initial_stack_pointer;
	assign active_count          = result.active_count;

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy, "block not busy after accepting a transaction")
	`ASSERT_IMPLY(a_done_busy, clk, arst_n, done, !front_valid && q_empty, "result while another transaction is queued")
	`ASSERT_IMPLY(a_push_space, clk, arst_n, push, !q_full, "queue push while full")

endmodule
